// ===== rtl/core/hpbfp_pkg.sv =====
`default_nettype none
package hpbfp_pkg;

    // Result kinds, carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_ACK      = 2'd0,
        KIND_CHANGE   = 2'd1,
        KIND_CSUM_ERR = 2'd2
    } kind_t;

    localparam logic [7:0] BYTE_ACK       = 8'h06;
    localparam logic [7:0] BYTE_NAK       = 8'h05;
    localparam logic [7:0] BYTE_CHAL_CMD  = 8'h03;
    localparam logic [7:0] BYTE_CHAL_ADDR = 8'h14;
    localparam logic [7:0] CMD_REG_DATA   = 8'hc0;
    localparam logic [15:0] REG_UNSEEN    = 16'hffff;
    localparam int TABLE_DEPTH            = 256;

endpackage
`default_nettype wire

// ===== rtl/core/hpbfp_ram.sv =====
`default_nettype none
module hpbfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/core/heat_pump_bus_frame_parser.sv =====
// A received byte is taken while the parser is in its idle state. The byte that ends a
// register data frame with a good checksum starts a walk over the payload positions and
// register entries, then a sweep over the table entries, held by any output stalls.
// A challenge or checksum error result passes through the pending and output registers.
// One byte per cycle while idle, none during a frame-end walk or a result; the walk is
// set by the single frame buffer read port. Reset: asynchronous active low, then a pass that clears both tables.
`default_nettype none
module heat_pump_bus_frame_parser #(
    parameter int FRAME_BYTES = 256,
    parameter int MAX_CHANGES = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write channel: cfg_data[0] is write_mode.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    // Input stream. s_tdata: [7:0] rx_byte.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    // Output stream. m_tdata: [7:0] reg_index, [23:8] new_value,
    // [39:24] old_value, [40] overflow, [47:41] zero.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    // m_tuser: [1:0] kind.
    output logic [1:0]       m_tuser,
    output logic             m_tlast
);
    import hpbfp_pkg::*;

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int AW = $clog2(FRAME_BYTES);
    localparam int PW = $clog2(FRAME_BYTES + 16);
    localparam int KW = $clog2(MAX_CHANGES + 1);
    localparam int TW = $clog2(TABLE_DEPTH);

    // One-hot sequencer. The parse states walk the payload with a single read
    // port; the sweep states compare both tables one entry at a time.
    typedef enum logic [11:0] {
        S_CLR  = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_CHK  = 12'b0000_0000_0100,
        S_RA   = 12'b0000_0000_1000,
        S_RNX  = 12'b0000_0001_0000,
        S_DEC  = 12'b0000_0010_0000,
        S_R4   = 12'b0000_0100_0000,
        S_R2   = 12'b0000_1000_0000,
        S_R3   = 12'b0001_0000_0000,
        S_SRD  = 12'b0010_0000_0000,
        S_SCMP = 12'b0100_0000_0000,
        S_END  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    logic          write_mode_reg;
    logic          in_frame_reg, in_frame_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] size_reg, size_next;
    logic [7:0]    xacc_reg, xacc_next;
    logic [7:0]    b0_reg, b0_next, b1_reg, b1_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [TW-1:0] j_reg, j_next;
    logic [KW-1:0] k_reg, k_next;
    logic          more_reg, more_next;
    logic          zflag_reg, zflag_next;
    logic [7:0]    a_reg, a_next, nx_reg, nx_next, c4_reg, c4_next, v2_reg, v2_next;

    // Pending result: held back one step so the final one can carry tlast.
    logic          pend_valid_reg, pend_valid_next;
    kind_t         pend_kind_reg, pend_kind_next;
    logic [7:0]    pend_idx_reg, pend_idx_next;
    logic [15:0]   pend_nv_reg, pend_nv_next, pend_ov_reg, pend_ov_next;

    logic          out_valid_reg, out_valid_next;
    kind_t         out_kind_reg, out_kind_next;
    logic [7:0]    out_idx_reg, out_idx_next;
    logic [15:0]   out_nv_reg, out_nv_next, out_ov_reg, out_ov_next;
    logic          out_ovf_reg, out_ovf_next, out_last_reg, out_last_next;

    logic          fb_we;
    logic [AW-1:0] fb_waddr, fb_raddr;
    logic [7:0]    fb_rdata, rdv;
    logic [PW-1:0] rd_pos;
    logic          rg_we, pv_we;
    logic [TW-1:0] rg_waddr, pv_waddr;
    logic [15:0]   rg_wdata, pv_wdata, rg_rdata, pv_rdata;

    logic          accept, out_free;
    logic [CW-1:0] cnt1;
    logic [9:0]    sz10;
    logic [PW-1:0] n_p;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign cnt1      = count_reg + CW'(1);
    assign sz10      = 10'(s_tdata) + 10'd5;
    assign n_p       = PW'(size_reg);
    assign rdv       = zflag_reg ? 8'h00 : fb_rdata;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_ovf_reg, out_ov_reg, out_nv_reg, out_idx_reg};

    // The frame buffer is written with each byte of the current frame at its count;
    // positions at or past the frame size read as zero.
    assign fb_we    = accept && in_frame_reg;
    assign fb_waddr = count_reg[AW-1:0];
    assign fb_raddr = rd_pos[AW-1:0];

    hpbfp_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_fbuf (
        .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(s_tdata),
        .raddr(fb_raddr), .rdata(fb_rdata)
    );

    hpbfp_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_regt (
        .clk(clk), .we(rg_we), .waddr(rg_waddr), .wdata(rg_wdata),
        .raddr(j_reg), .rdata(rg_rdata)
    );

    hpbfp_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_prevt (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(j_reg), .rdata(pv_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        in_frame_next   = in_frame_reg;
        count_next      = count_reg;
        size_next       = size_reg;
        xacc_next       = xacc_reg;
        b0_next         = b0_reg;
        b1_next         = b1_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        more_next       = more_reg;
        a_next          = a_reg;
        nx_next         = nx_reg;
        c4_next         = c4_reg;
        v2_next         = v2_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_idx_next   = pend_idx_reg;
        pend_nv_next    = pend_nv_reg;
        pend_ov_next    = pend_ov_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_idx_next    = out_idx_reg;
        out_nv_next     = out_nv_reg;
        out_ov_next     = out_ov_reg;
        out_ovf_next    = out_ovf_reg;
        out_last_next   = out_last_reg;
        rd_pos          = pos_reg;
        rg_we           = 1'b0;
        rg_waddr        = j_reg;
        rg_wdata        = REG_UNSEEN;
        pv_we           = 1'b0;
        pv_waddr        = j_reg;
        pv_wdata        = REG_UNSEEN;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLR:
            begin
                rg_we  = 1'b1;
                pv_we  = 1'b1;
                j_next = j_reg + TW'(1);
                if (j_reg == TW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && !in_frame_reg)
                begin
                    if (s_tdata == BYTE_ACK)
                    begin
                        in_frame_next = 1'b1;
                        count_next    = '0;
                        size_next     = '0;
                        xacc_next     = 8'h00;
                    end
                end
                else if (accept)
                begin
                    count_next = cnt1;
                    xacc_next  = xacc_reg ^ s_tdata;
                    if (count_reg == CW'(0))
                    begin
                        b0_next = s_tdata;
                    end
                    if (count_reg == CW'(1))
                    begin
                        b1_next = s_tdata;
                    end
                    priority if (cnt1 == CW'(3) && b0_reg == BYTE_CHAL_CMD
                                 && b1_reg == 8'h00 && s_tdata == BYTE_CHAL_ADDR)
                    begin
                        count_next = '0;
                        xacc_next  = 8'h00;
                        if (write_mode_reg)
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_ACK;
                            pend_idx_next   = 8'h00;
                            pend_nv_next    = 16'h0000;
                            pend_ov_next    = 16'h0000;
                            more_next       = 1'b0;
                            state_next      = S_END;
                        end
                    end
                    else if (cnt1 == CW'(4))
                    begin
                        // The sender bytes are the second and third of the frame.
                        priority if (s_tdata == BYTE_ACK)
                        begin
                            count_next = '0;
                            xacc_next  = 8'h00;
                        end
                        else if (s_tdata == BYTE_NAK || b1_reg != 8'h00
                                 || xacc_reg == b0_reg
                                 || sz10 > 10'(FRAME_BYTES))
                        begin
                            in_frame_next = 1'b0;
                            count_next    = '0;
                        end
                        else
                        begin
                            size_next = sz10[CW-1:0];
                        end
                    end
                    else if (cnt1 > CW'(4) && cnt1 == size_reg)
                    begin
                        in_frame_next = 1'b0;
                        count_next    = '0;
                        more_next     = 1'b0;
                        k_next        = '0;
                        if (xacc_reg != s_tdata)
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_CSUM_ERR;
                            pend_idx_next   = 8'h00;
                            pend_nv_next    = 16'h0000;
                            pend_ov_next    = 16'h0000;
                            state_next      = S_END;
                        end
                        else if (b0_reg == CMD_REG_DATA)
                        begin
                            pos_next   = PW'(4);
                            state_next = S_CHK;
                        end
                    end
                    else if (cnt1 >= CW'(FRAME_BYTES))
                    begin
                        in_frame_next = 1'b0;
                        count_next    = '0;
                    end
                end
            end
            S_CHK:
            begin
                if (pos_reg + PW'(3) < n_p)
                begin
                    state_next = S_RA;
                end
                else
                begin
                    j_next     = '0;
                    state_next = S_SRD;
                end
            end
            S_RA:
            begin
                rd_pos     = pos_reg;
                state_next = S_RNX;
            end
            S_RNX:
            begin
                a_next     = rdv;
                rd_pos     = pos_reg + PW'(1);
                state_next = S_DEC;
            end
            S_DEC:
            begin
                nx_next = rdv;
                if (a_reg == 8'h00 && (rdv != 8'h00 || pos_reg == PW'(4)))
                begin
                    rd_pos     = pos_reg + PW'(4);
                    state_next = S_R4;
                end
                else
                begin
                    pos_next   = pos_reg + PW'(1);
                    state_next = S_CHK;
                end
            end
            S_R4:
            begin
                c4_next    = rdv;
                rd_pos     = pos_reg + PW'(2);
                state_next = S_R2;
            end
            S_R2:
            begin
                v2_next = rdv;
                if (c4_reg == 8'h00 || pos_reg + PW'(6) == n_p)
                begin
                    rd_pos     = pos_reg + PW'(3);
                    state_next = S_R3;
                end
                else
                begin
                    rg_we      = 1'b1;
                    rg_waddr   = nx_reg;
                    rg_wdata   = {8'h00, rdv};
                    pos_next   = pos_reg + PW'(2);
                    state_next = S_CHK;
                end
            end
            S_R3:
            begin
                rg_we      = 1'b1;
                rg_waddr   = nx_reg;
                rg_wdata   = {v2_reg, rdv};
                pos_next   = pos_reg + PW'(3);
                state_next = S_CHK;
            end
            S_SRD:
            begin
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (rg_rdata != pv_rdata && k_reg < KW'(MAX_CHANGES)
                    && pend_valid_reg && !out_free)
                begin
                    state_next = S_SCMP;
                end
                else
                begin
                    if (rg_rdata != pv_rdata)
                    begin
                        pv_we    = 1'b1;
                        pv_wdata = rg_rdata;
                        if (k_reg < KW'(MAX_CHANGES))
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = pend_kind_reg;
                                out_idx_next   = pend_idx_reg;
                                out_nv_next    = pend_nv_reg;
                                out_ov_next    = pend_ov_reg;
                                out_ovf_next   = 1'b0;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_CHANGE;
                            pend_idx_next   = 8'(j_reg);
                            pend_nv_next    = rg_rdata;
                            pend_ov_next    = pv_rdata;
                            k_next          = k_reg + KW'(1);
                        end
                        else
                        begin
                            more_next = 1'b1;
                        end
                    end
                    j_next = j_reg + TW'(1);
                    if (j_reg == TW'(TABLE_DEPTH - 1))
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end
            S_END:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_idx_next    = pend_idx_reg;
                    out_nv_next     = pend_nv_reg;
                    out_ov_next     = pend_ov_reg;
                    out_ovf_next    = more_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign zflag_next = (rd_pos >= n_p);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            write_mode_reg <= 1'b0;
            in_frame_reg   <= 1'b0;
            count_reg      <= '0;
            size_reg       <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            more_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                write_mode_reg <= cfg_data;
            end
            in_frame_reg   <= in_frame_next;
            count_reg      <= count_next;
            size_reg       <= size_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            more_reg       <= more_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xacc_reg      <= xacc_next;
        b0_reg        <= b0_next;
        b1_reg        <= b1_next;
        pos_reg       <= pos_next;
        zflag_reg     <= zflag_next;
        a_reg         <= a_next;
        nx_reg        <= nx_next;
        c4_reg        <= c4_next;
        v2_reg        <= v2_next;
        pend_kind_reg <= pend_kind_next;
        pend_idx_reg  <= pend_idx_next;
        pend_nv_reg   <= pend_nv_next;
        pend_ov_reg   <= pend_ov_next;
        out_kind_reg  <= out_kind_next;
        out_idx_reg   <= out_idx_next;
        out_nv_reg    <= out_nv_next;
        out_ov_reg    <= out_ov_next;
        out_ovf_reg   <= out_ovf_next;
        out_last_reg  <= out_last_next;
    end

`ifndef SYNTHESIS
    // An acknowledge or a checksum error is always the only result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_ACK || m_tuser == KIND_CSUM_ERR) |-> m_tlast)
        else $error("single result without tlast");

    // The number of reported changes never passes the limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        k_reg <= KW'(MAX_CHANGES))
        else $error("change count past limit");

    // With nothing pending, the end state hands back to idle at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_END && !pend_valid_reg |=> state_reg == S_IDLE)
        else $error("end state hung");

    // Overflow is only flagged on the final change of a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[40] |-> m_tlast && m_tuser == KIND_CHANGE)
        else $error("overflow on a non-final result");
`endif

endmodule
`default_nettype wire
